[design/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and fixed-point helpers for the escape-time unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// fixed-point word and escape count widths
	localparam int Q_W   = 32;
	localparam int WIDE  = 66;
	localparam int CNT_W = 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN = 2'd0,
		REG_Y_ORIGIN = 2'd1,
		REG_STEP     = 2'd2
	} cfg_reg_t;

	// top-level sequencer states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_RUN   = 3'b100
	} ctl_state_t;

	// lane status toward the merge stage
	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} lane_stat_t;

	// clamp a wide signed value into the signed word range
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE-1:0] v);
		logic signed [WIDE-1:0] hi;
		logic signed [WIDE-1:0] lo;
		hi = WIDE'({1'b0, {(Q_W-1){1'b1}}});
		lo = -hi - WIDE'(1);
		if (v > hi) begin
			return {1'b0, {(Q_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(Q_W-1){1'b0}}};
		end
		return v[Q_W-1:0];
	endfunction

endpackage

[design/mbe_setup.sv]
// ----------------------------------------------------------------------------
// mbe_setup
// Two-stage computation of the point coordinates of every lane.
// ----------------------------------------------------------------------------
module mbe_setup import mbe_pkg::*; #(
	parameter int LANES      = 4,
	parameter int INDEX_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [INDEX_BITS-1:0]        row,
	input  logic [INDEX_BITS-1:0]        column,
	input  logic signed [Q_W-1:0]        x_origin,
	input  logic signed [Q_W-1:0]        y_origin,
	input  logic signed [Q_W-1:0]        step,
	output logic                         done,
	output logic signed [Q_W-1:0]        cx [LANES],
	output logic signed [Q_W-1:0]        cy
);

	localparam int IDX_W  = INDEX_BITS + 2;
	localparam int PROD_W = Q_W + IDX_W;

	logic                      valid_s1;
	logic                      valid_s2;
	logic signed [PROD_W-1:0]  px_s1 [LANES];
	logic signed [PROD_W-1:0]  py_s1;
	logic signed [IDX_W-1:0]   row_idx;
	logic signed [IDX_W-1:0]   col_idx [LANES];

	// lane indexes, column + k without wrapping
	always_comb begin
		row_idx = $signed(IDX_W'(row));
		for (int k = 0; k < LANES; k++) begin
			col_idx[k] = $signed(IDX_W'(column) + IDX_W'(k));
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: step times pixel index
	always_ff @(posedge clk) begin
		if (start) begin
			py_s1 <= PROD_W'(step) * PROD_W'(row_idx);
			for (int k = 0; k < LANES; k++) begin
				px_s1[k] <= PROD_W'(step) * PROD_W'(col_idx[k]);
			end
		end
	end

	// stage 2: add origin and saturate
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cy <= sat_q(WIDE'(y_origin) + WIDE'(py_s1));
			for (int k = 0; k < LANES; k++) begin
				cx[k] <= sat_q(WIDE'(x_origin) + WIDE'(px_s1[k]));
			end
		end
	end

	assign done = valid_s2;

endmodule

[design/mbe_lane.sv]
// ----------------------------------------------------------------------------
// mbe_lane
// One escape-time core: z = z^2 + c, with a multiply state and an accumulate state per iteration.
// ----------------------------------------------------------------------------
module mbe_lane import mbe_pkg::*; #(
	parameter int MAX_ITER  = 255,
	parameter int FRAC_BITS = 26
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [Q_W-1:0] cx,
	input  logic signed [Q_W-1:0] cy,
	output lane_stat_t            stat
);

	localparam logic signed [Q_W-1:0]   LIMIT = Q_W'(4) << FRAC_BITS;
	localparam logic [CNT_W-1:0]        N_MAX = CNT_W'(MAX_ITER);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_MUL  = 3'b010,
		L_ACC  = 3'b100
	} lane_state_t;

	lane_state_t              state_q;
	logic [CNT_W-1:0]         n_q;
	logic signed [Q_W-1:0]    x_q;
	logic signed [Q_W-1:0]    y_q;
	logic signed [Q_W-1:0]    cx_q;
	logic signed [Q_W-1:0]    cy_q;
	logic signed [2*Q_W-1:0]  pxx_q;
	logic signed [2*Q_W-1:0]  pyy_q;
	logic signed [2*Q_W-1:0]  pxy_q;

	logic signed [Q_W-1:0]    x2;
	logic signed [Q_W-1:0]    y2;
	logic signed [Q_W-1:0]    mag;
	logic signed [2*Q_W-1:0]  half;
	logic signed [Q_W-1:0]    x_nxt;
	logic signed [Q_W-1:0]    y_nxt;
	logic                     escaped;

	// scale products back, bound test and next point
	always_comb begin
		x2      = sat_q(WIDE'(pxx_q >>> FRAC_BITS));
		y2      = sat_q(WIDE'(pyy_q >>> FRAC_BITS));
		mag     = sat_q(WIDE'(x2) + WIDE'(y2));
		escaped = (mag >= LIMIT);
		half    = pxy_q >>> FRAC_BITS;
		y_nxt   = sat_q((WIDE'(half) <<< 1) + WIDE'(cy_q));
		x_nxt   = sat_q(WIDE'(x2) - WIDE'(y2) + WIDE'(cx_q));
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_MUL;
						n_q     <= '0;
					end
				end
				L_MUL: begin
					if (n_q == N_MAX) begin
						state_q <= L_IDLE;
					end else begin
						state_q <= L_ACC;
					end
				end
				L_ACC: begin
					if (escaped) begin
						state_q <= L_IDLE;
					end else begin
						state_q <= L_MUL;
						n_q     <= n_q + CNT_W'(1);
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// point, constant and product registers
	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			x_q  <= cx;
			y_q  <= cy;
			cx_q <= cx;
			cy_q <= cy;
		end else if (state_q == L_ACC && !escaped) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
		end
		if (state_q == L_MUL) begin
			pxx_q <= (2*Q_W)'(x_q) * (2*Q_W)'(x_q);
			pyy_q <= (2*Q_W)'(y_q) * (2*Q_W)'(y_q);
			pxy_q <= (2*Q_W)'(x_q) * (2*Q_W)'(y_q);
		end
	end

	assign stat.busy  = (state_q != L_IDLE);
	assign stat.count = n_q;

endmodule

[design/mbe_merge.sv]
// ----------------------------------------------------------------------------
// mbe_merge
// Waits for every lane to finish and holds the packed counts for the output.
// ----------------------------------------------------------------------------
module mbe_merge import mbe_pkg::*; #(
	parameter int LANES = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     run,
	input  lane_stat_t               stat [LANES],
	output logic                     load,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [LANES*CNT_W-1:0]   m_tdata
);

	logic all_done;
	logic valid_q;

	// all lanes idle
	always_comb begin
		all_done = 1'b1;
		for (int k = 0; k < LANES; k++) begin
			if (stat[k].busy) begin
				all_done = 1'b0;
			end
		end
	end

	assign load = run && all_done && (!valid_q || m_tready);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload, lane 0 lowest
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < LANES; k++) begin
				m_tdata[k*CNT_W +: CNT_W] <= stat[k].count;
			end
		end
	end

	assign m_tvalid = valid_q;

endmodule

[design/mandelbrot_escape_four_lanes_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_four_lanes_unit
// Escape-time counts for LANES adjacent pixels of one row, in parallel lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Write x_origin, y_origin and step (signed Q6.26) through the cfg port
//   while the unit is idle. Each request on the s_ side carries a row and
//   the column of lane 0; lane k works on pixel column+k.
//   After acceptance the setup stages form the point coordinates, then each lane
//   iterates z = z^2 + c with a multiply state and an accumulate state
//   per iteration. The result request on the m_ side carries one 8-bit count per lane.
//   One item is worked on at a time; s_tready is high while the sequencer is
//   idle. The result sits in an output register, so a new request is taken
//   while a finished result still waits; if the receiver stalls and a second
//   result is ready, the lanes hold it until the output register frees.
//   Reset clears the configuration registers to zero and leaves the unit idle and empty.
// ----------------------------------------------------------------------------
module mandelbrot_escape_four_lanes_unit import mbe_pkg::*; #(
	parameter int MAX_ITER   = 255,
	parameter int LANES      = 4,
	parameter int FRAC_BITS  = 26,
	parameter int INDEX_BITS = 12,
	localparam int IN_W      = ((2*INDEX_BITS + 7) / 8) * 8,
	localparam int OUT_W     = LANES * CNT_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data,
	// input requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,  // row, column, zero fill
	// result requests
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata   // count_0 .. count_(LANES-1)
);

	ctl_state_t             state_q;
	logic signed [Q_W-1:0]  x_origin_q;
	logic signed [Q_W-1:0]  y_origin_q;
	logic signed [Q_W-1:0]  step_q;
	logic                   accept;
	logic                   setup_done;
	logic                   load;
	logic signed [Q_W-1:0]  cx [LANES];
	logic signed [Q_W-1:0]  cy;
	lane_stat_t             stat [LANES];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= '0;
			y_origin_q <= '0;
			step_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_ORIGIN: x_origin_q <= cfg_data;
				REG_Y_ORIGIN: y_origin_q <= cfg_data;
				REG_STEP:     step_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_SETUP;
				ST_SETUP: if (setup_done) state_q <= ST_RUN;
				ST_RUN:   if (load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	mbe_setup #(
		.LANES      (LANES),
		.INDEX_BITS (INDEX_BITS)
	) u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.row      (s_tdata[INDEX_BITS-1:0]),
		.column   (s_tdata[2*INDEX_BITS-1:INDEX_BITS]),
		.x_origin (x_origin_q),
		.y_origin (y_origin_q),
		.step     (step_q),
		.done     (setup_done),
		.cx       (cx),
		.cy       (cy)
	);

	// escape-time lanes
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		mbe_lane #(
			.MAX_ITER  (MAX_ITER),
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (setup_done),
			.cx     (cx[k]),
			.cy     (cy),
			.stat   (stat[k])
		);
	end

	mbe_merge #(
		.LANES (LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.run      (state_q == ST_RUN),
		.stat     (stat),
		.load     (load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[sim/mandelbrot_escape_four_lanes_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_four_lanes_unit_tb
// Self-checking bench for the four-lane escape-time unit.
// A behavioral predictor in this file works out the four counts of each
// accepted request from its own copy of the view registers. A checker
// process compares every result request, lane by lane, in arrival order.
// Directed views cover the reset view, the classic full view and saturated
// views. Random views follow. Both sides of the stream stall in random
// bursts, and one long receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------
module mandelbrot_escape_four_lanes_unit_tb;
	import mbe_pkg::*;

	localparam int  CLK_PERIOD   = 12;
	localparam int  ITER_CAP     = 255;
	localparam int  LANE_COUNT   = 4;
	localparam int  FRAC         = 26;
	localparam int  INDEX_W      = 12;
	localparam int  IN_W         = ((2*INDEX_W + 7) / 8) * 8;
	localparam int  OUT_W        = LANE_COUNT * CNT_W;
	localparam int  DRAIN_CYCLES = 2*ITER_CAP + 20;
	localparam int  CYCLE_LIMIT  = 2_000_000;
	localparam int  REPORT_CAP   = 40;
	localparam int  RANDOM_VIEWS = 8;
	localparam int  VIEW_ITEMS   = 48;
	localparam int  HOLD_CYCLES  = 900;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 2'd3;

	// fixed-point bounds and escape threshold
	localparam longint Q_HI      = 2147483647;
	localparam longint Q_LO      = -Q_HI - 1;
	localparam longint ESCAPE_SQ = longint'(4) << FRAC;
	localparam int     Q_ONE     = 1 << FRAC;

	typedef logic [LANE_COUNT-1:0][CNT_W-1:0] lane_counts_t;

	typedef struct packed {
		logic [INDEX_W-1:0] row;
		logic [INDEX_W-1:0] column;
		lane_counts_t       counts;
	} pixel_group_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [Q_W-1:0]       cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;  // row, column, zero fill
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;  // count_0, count_1, count_2, count_3

	// view registers as the unit should hold them
	int view_x_origin;
	int view_y_origin;
	int view_step;

	pixel_group_t pending_groups[$];
	int           mismatch_count;
	int           requests_sent;
	int           views_used;
	int           lanes_at_cap;
	int           lanes_escaped_at_start;
	int           cycle_count;
	bit           pacing_on;
	int           sink_hold_req;

	mandelbrot_escape_four_lanes_unit #(
		.MAX_ITER   (ITER_CAP),
		.LANES      (LANE_COUNT),
		.FRAC_BITS  (FRAC),
		.INDEX_BITS (INDEX_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_groups.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic longint clamp_word(input longint v);
		if (v > Q_HI) return Q_HI;
		if (v < Q_LO) return Q_LO;
		return v;
	endfunction

	// iterations spent inside the radius-2 disk, capped
	function automatic logic [CNT_W-1:0] escape_iterations(input longint cx, input longint cy);
		longint x;
		longint y;
		longint x_sq;
		longint y_sq;
		longint radius_sq;
		longint xy_half;
		int     n;
		bit     escaped;
		x = cx;
		y = cy;
		n = 0;
		escaped = 1'b0;
		while (n < ITER_CAP && !escaped) begin
			x_sq      = clamp_word((x * x) >>> FRAC);
			y_sq      = clamp_word((y * y) >>> FRAC);
			radius_sq = clamp_word(x_sq + y_sq);
			if (radius_sq >= ESCAPE_SQ) begin
				escaped = 1'b1;
			end else begin
				xy_half = (x * y) >>> FRAC;
				y = clamp_word(2 * xy_half + cy);
				x = clamp_word(x_sq - y_sq + cx);
				n++;
			end
		end
		return CNT_W'(n);
	endfunction

	function automatic lane_counts_t predict_lane_counts(input logic [INDEX_W-1:0] row,
		input logic [INDEX_W-1:0] column);
		lane_counts_t counts;
		longint       cx;
		longint       cy;
		cy = clamp_word(longint'(view_y_origin) + longint'(view_step) * longint'(int'(row)));
		for (int k = 0; k < LANE_COUNT; k++) begin
			cx = clamp_word(longint'(view_x_origin)
				+ longint'(view_step) * longint'(int'(column) + k));
			counts[k] = escape_iterations(cx, cy);
		end
		return counts;
	endfunction

	// ------------------------------------------------------------------------
	// shared tasks
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$display("[%0t] MISMATCH %s", $realtime, what);
		end
	endtask

	// one register write; the enable stays high for back-to-back writes
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_X_ORIGIN: view_x_origin = int'(value);
			REG_Y_ORIGIN: view_y_origin = int'(value);
			REG_STEP:     view_step     = int'(value);
			default: ;
		endcase
	endtask

	task automatic program_view(input int x0, input int y0, input int stp);
		cfg_write(REG_X_ORIGIN, x0);
		cfg_write(REG_Y_ORIGIN, y0);
		cfg_write(REG_STEP, stp);
		cfg_we <= 1'b0;
		views_used++;
	endtask

	// offer one request and wait for it to be taken
	task automatic send_request(input logic [INDEX_W-1:0] row, input logic [INDEX_W-1:0] column);
		pixel_group_t group;
		if (pacing_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		group.row    = row;
		group.column = column;
		group.counts = predict_lane_counts(row, column);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({column, row});
		do @(posedge clk); while (!s_tready);
		pending_groups.push_back(group);
		requests_sent++;
		for (int k = 0; k < LANE_COUNT; k++) begin
			if (group.counts[k] == CNT_W'(ITER_CAP)) lanes_at_cap++;
			if (group.counts[k] == '0) lanes_escaped_at_start++;
		end
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_groups.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [INDEX_W-1:0] random_index();
		return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
	endfunction

	// ------------------------------------------------------------------------
	// receiver pacing: random stall bursts plus an on-demand long hold-off
	// ------------------------------------------------------------------------
	initial begin : sink_pacing
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (sink_hold_req > 0) begin
					stall_left    = sink_hold_req;
					sink_hold_req = 0;
				end else if (pacing_on && $urandom_range(0, 11) == 0) begin
					stall_left = $urandom_range(1, 14);
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		pixel_group_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_groups.size() == 0) begin
				report_mismatch($sformatf("result %h with no request outstanding", m_tdata));
			end else begin
				want = pending_groups.pop_front();
				for (int k = 0; k < LANE_COUNT; k++) begin
					if (m_tdata[k*CNT_W +: CNT_W] !== want.counts[k]) begin
						report_mismatch($sformatf("row %0d col %0d lane %0d: got %0d want %0d",
							want.row, want.column, k, m_tdata[k*CNT_W +: CNT_W],
							want.counts[k]));
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// registers at reset: every point is the origin, so all lanes hit the cap
	task automatic test_reset_view();
		send_request('0, '0);
		send_request('1, '1);
		wait_idle();
	endtask

	// full set, real -2.0 .. 0.5, imaginary -1.25 .. 1.25
	task automatic test_classic_view();
		program_view(-2 * Q_ONE, -(5 << 24), 40960);
		send_request('0, '0);                 // corner well outside: escapes at once
		send_request('1, '1);                 // last column, lanes past the field range
		send_request(12'd2048, 12'd2864);     // inside the main cardioid
		send_request(12'd2048, 12'd1600);     // period-two bulb
		send_request(12'hAAA, 12'h555);
		send_request(12'h555, 12'hAAA);
		send_request(12'd1700, 12'd2600);     // near the boundary
		wait_idle();
	endtask

	// a write to the spare index must leave the view alone
	task automatic test_unused_index();
		cfg_write(CFG_INDEX_UNUSED, $urandom());
		cfg_we <= 1'b0;
		send_request(12'd2048, 12'd2864);
		send_request(random_index(), random_index());
		wait_idle();
	endtask

	// extreme register values saturate the point coordinates
	task automatic test_saturation();
		program_view(int'(Q_HI), int'(Q_LO), int'(Q_HI));
		send_request('0, '0);
		send_request('1, '1);
		wait_idle();
		program_view(int'(Q_LO), int'(Q_HI), int'(Q_LO));
		send_request('0, '0);
		send_request(12'd1, 12'hFFC);
		wait_idle();
		// step of one ulp: the coordinates stay pinned near the origins
		program_view(-Q_ONE / 4, 0, -1);
		send_request('1, '1);
		send_request('0, '0);
		wait_idle();
	endtask

	// receiver holds off while requests keep coming, so the unit backs up
	task automatic test_back_pressure();
		program_view(-2 * Q_ONE, -(5 << 24), 40960);
		sink_hold_req = HOLD_CYCLES;
		for (int i = 0; i < 8; i++) begin
			send_request(INDEX_W'($urandom_range(0, 200)), random_index());
		end
		wait_idle();
	endtask

	// random views: mostly windows around the set, some arbitrary registers
	task automatic test_random_views();
		int x0;
		int y0;
		int stp;
		for (int v = 0; v < RANDOM_VIEWS; v++) begin
			if (v % 4 == 3) begin
				x0  = $urandom();
				y0  = $urandom();
				stp = $urandom();
			end else begin
				x0  = int'($urandom_range(0, 3 << FRAC)) - (5 << (FRAC - 1));
				y0  = int'($urandom_range(0, 5 << (FRAC - 1))) - (5 << (FRAC - 2));
				stp = $urandom_range(1 << 6, 1 << 16);
				if ($urandom_range(0, 3) == 0) stp = -stp;
			end
			// the last view runs with both sides at full rate
			pacing_on = (v != RANDOM_VIEWS - 1);
			program_view(x0, y0, stp);
			for (int i = 0; i < VIEW_ITEMS; i++) begin
				send_request(random_index(), random_index());
			end
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= REG_X_ORIGIN;
		cfg_data               <= '0;
		s_tvalid               <= 1'b0;
		s_tdata                <= '0;
		view_x_origin          = 0;
		view_y_origin          = 0;
		view_step              = 0;
		mismatch_count         = 0;
		requests_sent          = 0;
		views_used             = 1;
		lanes_at_cap           = 0;
		lanes_escaped_at_start = 0;
		cycle_count            = 0;
		sink_hold_req          = 0;
		pacing_on              = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_view();
		test_classic_view();
		test_unused_index();
		test_saturation();
		test_back_pressure();
		test_random_views();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests over %0d views in %0d cycles", requests_sent, views_used,
			cycle_count);
		$display("lanes at the iteration cap: %0d, lanes escaping at once: %0d",
			lanes_at_cap, lanes_escaped_at_start);
		if (mismatch_count == 0 && pending_groups.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
